// ===== sv/dqp_pkg.sv =====
`default_nettype none

package dqp_pkg;

   // Result status codes.
   typedef enum logic [1:0] {
      DQP_OK        = 2'd0,
      DQP_BAD_SHAPE = 2'd1,
      DQP_BAD_VALUE = 2'd2
   } dqp_status_type;

   // Characters the parser reacts to.
   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   // Limits of the dotted-quad form.
   localparam logic [9:0] MAX_BYTE   = 10'd255;
   localparam logic [2:0] MAX_DIGITS = 3'd3;
   localparam logic [2:0] GROUPS     = 3'd4;

   // Scan state carried from one character to the next.
   typedef struct packed {
      logic [9:0]  group_value;
      logic [2:0]  digits_in_group;
      logic [2:0]  dots_seen;
      logic [31:0] address_accum;
      logic        shape_bad;
      logic        convert_bad;
      logic        scan_stopped;
      logic        string_ended;
   } dqp_state_type;

endpackage

`default_nettype wire

// ===== sv/dqp_if.sv =====
`default_nettype none

// Character channel into the parser.
interface dqp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       last;

   modport source (output valid, output char_code, output last, input ready);
   modport sink   (input valid, input char_code, input last, output ready);
endinterface

// Result channel out of the parser.
interface dqp_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] address;
   logic [1:0]  status;

   modport source (output valid, output address, output status, input ready);
   modport sink   (input valid, input address, input status, output ready);
endinterface

`default_nettype wire

// ===== sv/ipv4_dotted_quad_parser.sv =====
// IPv4 dotted-decimal parser, one character per transfer.
// The req_chan channel carries one ASCII character per transfer; the transfer
// with last set closes the string. A zero character ends the string early and
// the characters after it are ignored until the transfer marked last.
// Exactly one result transfer leaves on rsp_chan for each string: the 32-bit
// address (first group in the top byte, zero unless the status is ok) and a
// status code (ok, bad shape, or shape ok but conversion rejected).
// Throughput is one character per clock unless a last character waits
// behind an untaken result. A character is captured in the input register
// and folded into the scan state in the following cycle; the result of a
// string passes from the input register into the result register, from
// which rsp_chan shows it.
// When the receiver stalls, the result register holds its transfer and the
// input register still takes one more character; characters that are not
// marked last keep flowing, since they produce no result. Only a last
// character waiting behind an untaken result holds off further input.
// Reset (synchronous, active high) empties both registers and clears the scan
// state; the block is ready for input once reset is released.
`default_nettype none

module ipv4_dotted_quad_parser (
   input wire logic    clock,
   input wire logic    reset,
   dqp_req_if.sink     req_chan,
   dqp_rsp_if.source   rsp_chan
);
   import dqp_pkg::*;

   // Input register.
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_char_ff, in_char_in;
   logic       in_last_ff, in_last_in;

   // Scan state.
   dqp_state_type st_ff, st_in;

   // Result register.
   logic           rsp_valid_ff, rsp_valid_in;
   logic [31:0]    rsp_address_ff, rsp_address_in;
   dqp_status_type rsp_status_ff, rsp_status_in;

   logic           advance;
   logic           accept;
   dqp_state_type  st_char;
   dqp_state_type  st_final;
   logic [9:0]     times_ten;
   dqp_status_type status_now;
   logic [31:0]    address_now;

   // Ends the current group: a group must have one to three digits and a
   // value no larger than a byte, otherwise the conversion is rejected.
   function automatic dqp_state_type close_group(input dqp_state_type s);
      dqp_state_type r;
      r = s;
      if (s.digits_in_group == 3'd0 || s.digits_in_group > MAX_DIGITS ||
          s.group_value > MAX_BYTE) begin
         r.convert_bad = 1'b1;
      end else begin
         r.address_accum = {s.address_accum[23:0], s.group_value[7:0]};
      end
      r.group_value     = '0;
      r.digits_in_group = '0;
      return r;
   endfunction

   // The item in the input register moves on unless it is a last character
   // whose result would overwrite one the receiver has not yet taken.
   assign advance = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign accept = req_chan.valid && req_chan.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_char_in  = in_char_ff;
      in_last_in  = in_last_ff;
      if (accept) begin
         in_valid_in = 1'b1;
         in_char_in  = req_chan.char_code;
         in_last_in  = req_chan.last;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   // A group holds at most two digits when another digit is appended, so the
   // value times ten stays below 1000 and fits the group register.
   assign times_ten = {st_ff.group_value[6:0], 3'b000} + {st_ff.group_value[8:0], 1'b0};

   // Fold one character into the scan state.
   always_comb begin
      st_char = st_ff;
      if (!st_ff.string_ended) begin
         if (in_char_ff == CHAR_NUL) begin
            st_char.string_ended = 1'b1;
         end else if (in_char_ff == CHAR_SPACE) begin
            // A space stops the shape scan and always rejects the conversion.
            st_char.scan_stopped = 1'b1;
            st_char.convert_bad  = 1'b1;
         end else if (!st_ff.scan_stopped) begin
            if (in_char_ff == CHAR_DOT) begin
               st_char = close_group(st_ff);
               if (st_ff.dots_seen < GROUPS) begin
                  st_char.dots_seen = st_ff.dots_seen + 3'd1;
               end
            end else if (in_char_ff inside {[CHAR_ZERO:CHAR_NINE]}) begin
               if (st_ff.digits_in_group < MAX_DIGITS) begin
                  // The low nibble of an ASCII digit is its value.
                  st_char.group_value     = times_ten + {6'd0, in_char_ff[3:0]};
                  st_char.digits_in_group = st_ff.digits_in_group + 3'd1;
               end else begin
                  // Too many digits: count saturates and the value is frozen.
                  st_char.digits_in_group = MAX_DIGITS + 3'd1;
                  st_char.shape_bad       = 1'b1;
               end
            end else begin
               st_char.shape_bad   = 1'b1;
               st_char.convert_bad = 1'b1;
            end
         end
      end
   end

   // At the end of the string the open group is closed, unless a space
   // stopped the scan, and the status is judged shape first.
   always_comb begin
      st_final = st_char;
      if (!st_char.scan_stopped) begin
         st_final = close_group(st_char);
      end
      address_now = '0;
      if (st_final.shape_bad || st_final.dots_seen != MAX_DIGITS) begin
         status_now = DQP_BAD_SHAPE;
      end else if (st_final.convert_bad) begin
         status_now = DQP_BAD_VALUE;
      end else begin
         status_now  = DQP_OK;
         address_now = st_final.address_accum;
      end
   end

   always_comb begin
      st_in          = st_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_address_in = rsp_address_ff;
      rsp_status_in  = rsp_status_ff;
      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (advance) begin
         if (in_last_ff) begin
            // The string is finished: start the next one from a clean state.
            st_in          = '0;
            rsp_valid_in   = 1'b1;
            rsp_address_in = address_now;
            rsp_status_in  = status_now;
         end else begin
            st_in = st_char;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         st_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         st_ff        <= st_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_char_ff     <= in_char_in;
      in_last_ff     <= in_last_in;
      rsp_address_ff <= rsp_address_in;
      rsp_status_ff  <= rsp_status_in;
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.address = rsp_address_ff;
   assign rsp_chan.status  = rsp_status_ff;

endmodule

`default_nettype wire

// ===== sv/dqp_checker.sv =====
`default_nettype none

module dqp_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [31:0] rsp_address,
   input wire logic [1:0]  rsp_status
);
   import dqp_pkg::*;

   // A result that is not taken stays offered.
   a_rsp_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn before transfer");

   // A stalled result keeps its payload.
   a_rsp_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_address) && $stable(rsp_status))
      else $error("stalled result changed");

   // Only the three defined status codes are ever reported.
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == DQP_OK || rsp_status == DQP_BAD_SHAPE ||
                     rsp_status == DQP_BAD_VALUE))
      else $error("undefined status code");

   // A rejected string never leaks a partial address.
   a_address_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != DQP_OK |-> rsp_address == 32'd0)
      else $error("address not zero on rejected string");

   // Reset leaves no result pending.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result offered right after reset");

endmodule

bind ipv4_dotted_quad_parser dqp_checker u_dqp_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_address (rsp_chan.address),
   .rsp_status  (rsp_chan.status)
);

`default_nettype wire
